[design/contiguous_bitmap_block_allocator_defines.svh]
// Assertion macros used by the allocator top level.
`ifndef CONTIGUOUS_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define CBA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Invariant checked on every rising clock edge outside reset.
`define CBA_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

[design/cba_pkg.sv]
// Package with constants, types and state encoding for the block allocator.
`default_nettype none
package cba_pkg;
    localparam int WORD_BITS_DEF  = 64;
    localparam int WORD_COUNT_DEF = 16;
    localparam logic [31:0] HEADER_BYTES = 32'd16;
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_NO_FREE   = 3'd2;
    localparam logic [2:0] ST_NO_RUN    = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;
    localparam logic [0:0] MODE_ALLOC   = 1'b0;
    localparam logic [0:0] MODE_RELEASE = 1'b1;
    localparam logic [0:0] REG_BLOCK_BYTES  = 1'b0;
    localparam logic [0:0] REG_WORDS_IN_USE = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN,
        S_MOD_RD,
        S_MOD_WAIT,
        S_MOD_WR,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

[design/contiguous_bitmap_block_allocator.sv]
// Top level of the first-fit contiguous bitmap block allocator.
//
//   Channel   Handshake                 Payload                                          Dir
//   request   start / busy              mode, request_bytes, start_block, release_count  in
//   result    done (one-cycle strobe)   status, granted_start, granted_count, free_blocks out
//   config    psel, penable, pready     pwrite, paddr, pwdata, prdata                    in/out
//
// One request is processed at a time. An allocate runs a bit-serial divider in S_DIV
// and the size checks in S_CHECK, then scans the free bitmap one bit per cycle, with
// a read state S_SCAN_RD before each word, and rewrites each word of the granted run
// through S_MOD_RD, S_MOD_WAIT and S_MOD_WR. A release passes through S_CHECK and the
// same modify states for each word it touches. The result word follows S_DONE, and busy
// drops in the cycle that shows it. After reset and after every write to words_in_use
// while idle, a clearing pass writes all WORD_COUNT bitmap words, one per cycle, while
// busy is high. The receiver cannot stall: done marks each result for exactly one cycle.
`default_nettype none
`include "contiguous_bitmap_block_allocator_defines.svh"
module contiguous_bitmap_block_allocator #(
    parameter int WORD_BITS  = cba_pkg::WORD_BITS_DEF,
    parameter int WORD_COUNT = cba_pkg::WORD_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [31:0] request_bytes,
    input  wire logic [9:0]  start_block,
    input  wire logic [10:0] release_count,
    output logic             done,
    output logic [2:0]       status,
    output logic [9:0]       granted_start,
    output logic [10:0]      granted_count,
    output logic [10:0]      free_blocks,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import cba_pkg::*;

    localparam int WA = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BA = $clog2(WORD_BITS);
    // Block index width covering capacity: wide enough for WORD_BITS*WORD_COUNT.
    localparam int IW = $clog2(WORD_BITS * WORD_COUNT + 1) + 1;
    localparam int CW = $clog2(WORD_COUNT + 1);

    state_t state_reg, state_next;

    logic [20:0]   block_bytes_reg;
    logic [4:0]    words_in_use_reg;
    logic [10:0]   free_counter_reg;
    logic          mode_reg;
    logic [9:0]    start_blk_reg;
    logic [10:0]   cnt_reg;
    // Divider state: quotient register reused as dividend, 34-bit numerator.
    logic [33:0]   quo_reg;
    logic [21:0]   rem_reg;
    logic [5:0]    step_reg;
    logic [IW-1:0] pos_reg;
    logic [IW-1:0] run_reg;
    logic [IW-1:0] first_reg;
    logic [WA-1:0] waddr_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [2:0]    status_reg;
    logic [9:0]    gstart_reg;
    logic [10:0]   gcount_reg;
    logic          done_reg;
    logic [WA:0]   clr_reg;

    // Effective configuration.
    logic [CW-1:0] eff_words;
    logic [IW-1:0] cap;
    logic [20:0]   eff_bs;
    always_comb
    begin
        if (words_in_use_reg == 5'd0)
        begin
            eff_words = CW'(1);
        end
        else if (32'(words_in_use_reg) > WORD_COUNT)
        begin
            eff_words = CW'(WORD_COUNT);
        end
        else
        begin
            eff_words = CW'(words_in_use_reg);
        end
        cap = IW'(eff_words) << BA;
        if (block_bytes_reg == 21'd0)
        begin
            eff_bs = 21'd128;
        end
        else if (block_bytes_reg > 21'd1048576)
        begin
            eff_bs = 21'd1048576;
        end
        else
        begin
            eff_bs = {(block_bytes_reg[20:7] + 14'(|block_bytes_reg[6:0])), 7'd0};
        end
    end

    // Memory port.
    logic                 ram_we;
    logic [WA-1:0]        ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    cba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORD_COUNT)) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Configuration port.
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        case (paddr[2])
            REG_BLOCK_BYTES:  prdata = {11'd0, block_bytes_reg};
            REG_WORDS_IN_USE: prdata = {27'd0, words_in_use_reg};
            default:          prdata = 32'd0;
        endcase
        if (paddr[1:0] != 2'd0)
        begin
            prdata = 32'd0;
        end
    end

    // Division step: restoring, one quotient bit per cycle.
    logic [22:0] trial;
    assign trial = {rem_reg, quo_reg[33]} - {2'b00, eff_bs};

    // Current scan bit.
    logic [BA-1:0] bit_idx;
    logic          cur_free;
    assign bit_idx  = pos_reg[BA-1:0];
    assign cur_free = ram_rdata[bit_idx];

    // Run bounds for modify phase.
    logic [IW-1:0] run_start, run_end;
    logic          set_val;
    assign set_val   = (mode_reg != MODE_ALLOC);
    assign run_start = set_val ? IW'(start_blk_reg) : first_reg;
    assign run_end   = run_start + IW'(cnt_reg);

    // Word being rewritten covers bits [base, base+WORD_BITS).
    logic [IW-1:0]        wbase;
    logic [WORD_BITS-1:0] mod_mask;
    assign wbase = IW'(waddr_reg) << BA;
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            mod_mask[b] = ((wbase + IW'(b)) >= run_start) && ((wbase + IW'(b)) < run_end);
        end
    end

    logic [WA-1:0] last_word;
    assign last_word = WA'((run_end - IW'(1)) >> BA);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (clr_reg == (WA+1)'(WORD_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_wr && paddr[2] == REG_WORDS_IN_USE && paddr[1:0] == 2'd0)
                begin
                    state_next = S_INIT;
                end
                else if (start)
                begin
                    state_next = (mode == MODE_ALLOC) ? S_DIV : S_CHECK;
                end
            end
            S_DIV:     state_next = (step_reg == 6'd33) ? S_CHECK : S_DIV;
            S_CHECK:
            begin
                if (mode_reg == MODE_ALLOC)
                begin
                    if (quo_reg > 34'(cap) || quo_reg > 34'(free_counter_reg))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else if (cnt_reg == 11'd0 || (IW'(start_blk_reg) + IW'(cnt_reg)) > cap)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MOD_RD;
                end
            end
            S_SCAN_RD: state_next = S_SCAN;
            S_SCAN:
            begin
                if (cur_free && (run_reg + IW'(1)) == IW'(cnt_reg))
                begin
                    state_next = S_MOD_RD;
                end
                else if (pos_reg + IW'(1) >= cap)
                begin
                    state_next = S_DONE;
                end
                else if (bit_idx == BA'(WORD_BITS - 1))
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_MOD_RD:   state_next = S_MOD_WAIT;
            S_MOD_WAIT: state_next = S_MOD_WR;
            S_MOD_WR:   state_next = (waddr_reg == last_word) ? S_DONE : S_MOD_RD;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Memory control outputs.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = waddr_reg;
        ram_wdata = word_reg;
        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg[WA-1:0];
                ram_wdata = '1;
            end
            S_SCAN_RD: ram_addr = WA'(pos_reg >> BA);
            S_SCAN:    ram_addr = WA'(pos_reg >> BA);
            S_MOD_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = set_val ? (word_reg | mod_mask) : (word_reg & ~mod_mask);
            end
            default:   ram_addr = waddr_reg;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // Datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            block_bytes_reg  <= 21'd128;
            words_in_use_reg <= 5'd16;
            free_counter_reg <= 11'(WORD_BITS * WORD_COUNT);
            clr_reg          <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE);
            if (cfg_wr && paddr[1:0] == 2'd0)
            begin
                if (paddr[2] == REG_BLOCK_BYTES)
                begin
                    block_bytes_reg <= pwdata[20:0];
                end
                else
                begin
                    words_in_use_reg <= pwdata[4:0];
                    clr_reg          <= '0;
                end
            end
            if (state_reg == S_INIT)
            begin
                clr_reg          <= clr_reg + (WA+1)'(1);
                free_counter_reg <= 11'(cap);
            end
            if (state_reg == S_MOD_WR && waddr_reg == last_word)
            begin
                if (set_val)
                begin
                    free_counter_reg <= (12'(free_counter_reg) + 12'(cnt_reg) > 12'(cap))
                                        ? 11'(cap) : 11'(free_counter_reg + cnt_reg);
                end
                else
                begin
                    free_counter_reg <= free_counter_reg - cnt_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                mode_reg      <= mode;
                start_blk_reg <= start_block;
                cnt_reg       <= release_count;
                quo_reg       <= 34'(request_bytes) + 34'(HEADER_BYTES) + 34'(eff_bs) - 34'd1;
                rem_reg       <= '0;
                step_reg      <= '0;
                status_reg    <= ST_OK;
                gstart_reg    <= '0;
                gcount_reg    <= '0;
            end
            S_DIV:
            begin
                // One quotient bit per cycle for the 34-bit numerator.
                if (!trial[22])
                begin
                    rem_reg <= trial[21:0];
                    quo_reg <= {quo_reg[32:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[20:0], quo_reg[33]};
                    quo_reg <= {quo_reg[32:0], 1'b0};
                end
                step_reg <= step_reg + 6'd1;
            end
            S_CHECK:
            begin
                pos_reg <= '0;
                run_reg <= '0;
                if (mode_reg == MODE_ALLOC)
                begin
                    cnt_reg <= quo_reg[10:0];
                    if (quo_reg > 34'(cap))
                    begin
                        status_reg <= ST_TOO_LARGE;
                    end
                    else if (quo_reg > 34'(free_counter_reg))
                    begin
                        status_reg <= ST_NO_FREE;
                    end
                end
                else
                begin
                    waddr_reg <= WA'(IW'(start_blk_reg) >> BA);
                    if (cnt_reg != 11'd0 && (IW'(start_blk_reg) + IW'(cnt_reg)) > cap)
                    begin
                        status_reg <= ST_RANGE;
                    end
                end
            end
            S_SCAN:
            begin
                pos_reg <= pos_reg + IW'(1);
                run_reg <= cur_free ? run_reg + IW'(1) : '0;
                if (cur_free && (run_reg + IW'(1)) == IW'(cnt_reg))
                begin
                    first_reg  <= pos_reg + IW'(1) - IW'(cnt_reg);
                    waddr_reg  <= WA'((pos_reg + IW'(1) - IW'(cnt_reg)) >> BA);
                    gstart_reg <= 10'(pos_reg + IW'(1) - IW'(cnt_reg));
                    gcount_reg <= cnt_reg;
                end
                else if (pos_reg + IW'(1) >= cap)
                begin
                    status_reg <= ST_NO_RUN;
                end
            end
            S_MOD_WAIT: word_reg <= ram_rdata;
            S_MOD_WR:   waddr_reg <= waddr_reg + WA'(1);
            default:    word_reg <= word_reg;
        endcase
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_start = gstart_reg;
    assign granted_count = gcount_reg;
    assign free_blocks   = free_counter_reg;

    `CBA_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy, "result word while still busy")
    `CBA_ASSERT_IMPL(a_fail_zero, clk, rst_n, done && status != ST_OK,
        granted_count == 11'd0, "failed request reports a granted run")
    `CBA_ASSERT_ALWAYS(a_free_cap, clk, rst_n, busy || free_blocks <= 11'(cap),
        "free count exceeds capacity")
endmodule
`default_nettype wire

[design/cba_ram.sv]
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module cba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire
